// ===== rtl/mmss_pkg.sv =====
// Package for the mm:ss seven-segment scan clock.
// Digit slot and register index codes, BCD types, segment font and select codes.
// No dependencies.
`default_nettype none

package mmss_pkg;

  localparam int unsigned TimeW  = 6;
  localparam int unsigned ScanW  = 10;
  localparam int unsigned InW    = 8;
  localparam int unsigned OutW   = 32;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned DataW  = 32;

  localparam logic [TimeW-1:0] StartMinRst = 6'd18;
  localparam logic [TimeW-1:0] StartSecRst = 6'd58;
  localparam logic [ScanW-1:0] ScansRst    = 10'd100;

  typedef enum logic [1:0] {
    SlotMinTens  = 2'd0,
    SlotMinUnits = 2'd1,
    SlotSecTens  = 2'd2,
    SlotSecUnits = 2'd3
  } slot_e;

  typedef enum logic [1:0] {
    RegStartMin = 2'd0,
    RegStartSec = 2'd1,
    RegScans    = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [2:0] tens;
    logic [3:0] units;
  } bcd_t;

  typedef struct packed {
    bcd_t mins;
    bcd_t secs;
  } time_t;

  // Clamp 0..63 to 0..59 and split into BCD.
  function automatic bcd_t to_bcd(input logic [TimeW-1:0] v);
    bcd_t r;
    logic [TimeW-1:0] c;
    c = (v > 6'd59) ? 6'd59 : v;
    if (c >= 6'd50) begin
      r.tens = 3'd5; r.units = 4'(c - 6'd50);
    end else if (c >= 6'd40) begin
      r.tens = 3'd4; r.units = 4'(c - 6'd40);
    end else if (c >= 6'd30) begin
      r.tens = 3'd3; r.units = 4'(c - 6'd30);
    end else if (c >= 6'd20) begin
      r.tens = 3'd2; r.units = 4'(c - 6'd20);
    end else if (c >= 6'd10) begin
      r.tens = 3'd1; r.units = 4'(c - 6'd10);
    end else begin
      r.tens = 3'd0; r.units = 4'(c);
    end
    return r;
  endfunction

  // BCD pair back to binary: tens*10 + units.
  function automatic logic [TimeW-1:0] from_bcd(input bcd_t b);
    return 6'({b.tens, 3'b000}) + 6'({b.tens, 1'b0}) + 6'(b.units);
  endfunction

  // Active-high gfedcba font; codes above nine wrap as digit mod ten.
  function automatic logic [7:0] seg_font(input logic [3:0] d);
    logic [7:0] f;
    case (d)
      4'd0, 4'd10: f = 8'h3F;
      4'd1, 4'd11: f = 8'h06;
      4'd2, 4'd12: f = 8'h5B;
      4'd3, 4'd13: f = 8'h4F;
      4'd4, 4'd14: f = 8'h66;
      4'd5, 4'd15: f = 8'h6D;
      4'd6:        f = 8'h7D;
      4'd7:        f = 8'h07;
      4'd8:        f = 8'h7F;
      4'd9:        f = 8'h6F;
      default:     f = 8'h3F;
    endcase
    return f;
  endfunction

  function automatic logic [7:0] sel_code(input slot_e s);
    logic [7:0] c;
    case (s)
      SlotMinTens:  c = 8'hFE;
      SlotMinUnits: c = 8'hFD;
      SlotSecTens:  c = 8'hFB;
      SlotSecUnits: c = 8'hF7;
      default:      c = 8'hFF;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mmss_seven_segment_scan_clock.sv =====
// Multiplexed four-digit mm:ss seven-segment scan clock, one request per digit slot.
// Each result is registered: it appears in the cycle after its request is accepted.
// Throughput: one request per cycle unless m_axis_tready stalls; the result register and
//   slot/BCD counters are the only stages, so back-to-back requests run at full rate.
// Reset (rst_ni, async active low): start 18:58, 100 scans per second, slot 0,
//   scan count 0, no result pending. Depends on mmss_pkg.
`default_nettype none

module mmss_seven_segment_scan_clock
  import mmss_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // request stream
  input  wire logic             s_axis_tvalid,
  output      logic             s_axis_tready,
  input  wire logic [InW-1:0]   s_axis_tdata,   // [0] reload, [7:1] zero
  // result stream
  output      logic             m_axis_tvalid,
  input  wire logic             m_axis_tready,
  output      logic [OutW-1:0]  m_axis_tdata,   // [7:0] digit_select, [15:8] segments,
                                                // [21:16] minutes, [27:22] seconds, [31:28] 0
  // configuration
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output      logic [DataW-1:0] prdata,
  output      logic             pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [TimeW-1:0] start_min_q, start_sec_q;
  logic [ScanW-1:0] scans_q;
  logic             cfg_wr;
  reg_idx_e         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_min_q <= StartMinRst;
      start_sec_q <= StartSecRst;
      scans_q     <= ScansRst;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegStartMin: start_min_q <= pwdata[TimeW-1:0];
        RegStartSec: start_sec_q <= pwdata[TimeW-1:0];
        RegScans:    scans_q     <= pwdata[ScanW-1:0];
        default:     ;  // unmapped address, write dropped
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      RegStartMin: prdata = DataW'(start_min_q);
      RegStartSec: prdata = DataW'(start_sec_q);
      RegScans:    prdata = DataW'(scans_q);
      default:     prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshake: the result register frees up when empty or being drained
  // ---------------------------------------------------------------------------
  logic s_fire;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  // ---------------------------------------------------------------------------
  // Slot / scan / time state
  // ---------------------------------------------------------------------------
  slot_e            slot_q, slot_d, slot_cur;
  logic [ScanW-1:0] scan_q, scan_d, scan_cur, scan_inc, limit;
  time_t            time_q, time_d, time_cur, time_load;
  logic             reload, sec_tick;
  logic [3:0]       digit;
  logic [7:0]       seg_byte;
  logic [OutW-1:0]  res_d;

  assign reload = s_axis_tdata[0];

  always_comb begin
    time_load.mins = to_bcd(start_min_q);
    time_load.secs = to_bcd(start_sec_q);

    // a reload tick shows slot 0 of the freshly loaded start time
    time_cur = reload ? time_load : time_q;
    slot_cur = reload ? SlotMinTens : slot_q;
    scan_cur = reload ? '0 : scan_q;

    case (slot_cur)
      SlotMinTens:  digit = {1'b0, time_cur.mins.tens};
      SlotMinUnits: digit = time_cur.mins.units;
      SlotSecTens:  digit = {1'b0, time_cur.secs.tens};
      SlotSecUnits: digit = time_cur.secs.units;
      default:      digit = '0;
    endcase

    // active low; colon point lit on minutes units only
    seg_byte = seg_font(digit) ^ ((slot_cur == SlotMinUnits) ? 8'h7F : 8'hFF);

    res_d = {4'b0000, from_bcd(time_cur.secs), from_bcd(time_cur.mins),
             seg_byte, sel_code(slot_cur)};

    // scan counter: a zero limit behaves as one; wrap of the counter also ticks
    limit    = (scans_q == '0) ? ScanW'(1) : scans_q;
    scan_inc = scan_cur + ScanW'(1);
    sec_tick = 1'b0;
    scan_d   = scan_cur;
    if (slot_cur == SlotSecUnits) begin
      if (scan_inc >= limit || scan_inc == '0) begin
        sec_tick = 1'b1;
        scan_d   = '0;
      end else begin
        scan_d   = scan_inc;
      end
    end

    slot_d = slot_e'(slot_cur + 2'd1);

    // BCD seconds advance with carries; past 59:59 reload start time
    time_d = time_cur;
    if (sec_tick) begin
      if (time_cur.secs.units < 4'd9) begin
        time_d.secs.units = time_cur.secs.units + 4'd1;
      end else begin
        time_d.secs.units = '0;
        if (time_cur.secs.tens < 3'd5) begin
          time_d.secs.tens = time_cur.secs.tens + 3'd1;
        end else begin
          time_d.secs.tens = '0;
          if (time_cur.mins.units < 4'd9) begin
            time_d.mins.units = time_cur.mins.units + 4'd1;
          end else begin
            time_d.mins.units = '0;
            if (time_cur.mins.tens < 3'd5) begin
              time_d.mins.tens = time_cur.mins.tens + 3'd1;
            end else begin
              time_d = time_load;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q         <= SlotMinTens;
      scan_q         <= '0;
      time_q.mins    <= to_bcd(StartMinRst);
      time_q.secs    <= to_bcd(StartSecRst);
    end else if (s_fire) begin
      slot_q <= slot_d;
      scan_q <= scan_d;
      time_q <= time_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (s_fire) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      m_axis_tdata <= res_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_bcd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    time_q.secs.units <= 4'd9 && time_q.secs.tens <= 3'd5 &&
    time_q.mins.units <= 4'd9 && time_q.mins.tens <= 3'd5)
    else $error("BCD digit out of range");

  a_slot_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && !reload |=> slot_q == slot_e'($past(slot_q) + 2'd1))
    else $error("digit slot did not advance");

  a_one_select: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> $onehot(~m_axis_tdata[3:0]) && m_axis_tdata[7:4] == 4'hF)
    else $error("digit select not a single active-low enable");

  a_colon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[15] == 1'b0) == (m_axis_tdata[7:0] == 8'hFD))
    else $error("colon point on wrong digit");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the mm:ss seven-segment scan clock: stream requests in,
// one display result per request out, APB register writes between phases.
// Depends on mmss_pkg and mmss_seven_segment_scan_clock.

module tb;
  import mmss_pkg::*;

  // result tdata, lowest bits first: digit_select, segments, minutes, seconds, zero pad
  typedef struct packed {
    logic [3:0]       pad;
    logic [TimeW-1:0] seconds;
    logic [TimeW-1:0] minutes;
    logic [7:0]       segments;
    logic [7:0]       digit_select;
  } scan_out_t;

  // active-high gfedcba patterns for digits 0..9
  localparam logic [9:0][7:0] SegFont = {8'h6F, 8'h7F, 8'h07, 8'h7D, 8'h6D,
                                         8'h66, 8'h4F, 8'h5B, 8'h06, 8'h3F};
  // first byte address past the register map; writes there must be dropped
  localparam logic [AddrW-1:0] AddrSpare = AddrW'(4 * (int'(RegScans) + 1));
  localparam int unsigned      RandItems = 1850;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [InW-1:0]   s_axis_tdata = '0;   // [0] reload, [7:1] zero
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OutW-1:0]  m_axis_tdata;        // [7:0] digit_select, [15:8] segments,
                                         // [21:16] minutes, [27:22] seconds, [31:28] 0
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  // predictor: register copies and display state
  logic [TimeW-1:0] cfg_start_min;
  logic [TimeW-1:0] cfg_start_sec;
  logic [ScanW-1:0] cfg_scans;
  slot_e            cur_slot;
  logic [ScanW-1:0] scan_cnt;
  bcd_t             shown_min;
  bcd_t             shown_sec;

  scan_out_t display_due[$];   // expected results, oldest first
  bit        reload_feed[$];   // requests not yet offered
  int        slots_taken = 0;  // accepted requests
  int        errors = 0;
  int        send_gap = 0;
  int        recv_gap = 0;
  bit        send_quiet = 1'b0;
  bit        recv_quiet = 1'b0;
  logic      holding = 1'b0;   // long receiver hold-off

  mmss_seven_segment_scan_clock DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- helpers

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= 40) $display("%0t mismatch %s: got 0x%0h want 0x%0h", $time, what, got, want);
  endtask

  function automatic int idle_len(input bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic [AddrW-1:0] reg_addr(input reg_idx_e idx);
    return AddrW'({idx, 2'b00});
  endfunction

  // start values above 59 saturate
  function automatic bcd_t split_time(input logic [TimeW-1:0] v);
    bcd_t             r;
    logic [TimeW-1:0] c;
    c = (v > 6'd59) ? 6'd59 : v;
    r.tens  = 3'(c / 10);
    r.units = 4'(c % 10);
    return r;
  endfunction

  function automatic void load_start_time();
    shown_min = split_time(cfg_start_min);
    shown_sec = split_time(cfg_start_sec);
  endfunction

  // one second with decimal carries; past 59:59 the start time comes back
  function automatic void tick_second();
    if (shown_sec.units < 4'd9) shown_sec.units = shown_sec.units + 4'd1;
    else begin
      shown_sec.units = '0;
      if (shown_sec.tens < 3'd5) shown_sec.tens = shown_sec.tens + 3'd1;
      else begin
        shown_sec.tens = '0;
        if (shown_min.units < 4'd9) shown_min.units = shown_min.units + 4'd1;
        else begin
          shown_min.units = '0;
          if (shown_min.tens < 3'd5) shown_min.tens = shown_min.tens + 3'd1;
          else load_start_time();
        end
      end
    end
  endfunction

  // Expected display for one scan slot, then step slot / scan / time.
  function automatic void show_slot(input logic reload);
    scan_out_t        exp_out;
    logic [3:0]       digit;
    logic [ScanW-1:0] limit;
    if (reload) begin
      load_start_time();
      cur_slot = SlotMinTens;
      scan_cnt = '0;
    end
    case (cur_slot)
      SlotMinTens:  digit = {1'b0, shown_min.tens};
      SlotMinUnits: digit = shown_min.units;
      SlotSecTens:  digit = {1'b0, shown_sec.tens};
      default:      digit = shown_sec.units;
    endcase
    exp_out              = '0;
    exp_out.digit_select = ~(8'h01 << cur_slot);
    // active low; colon is the point on the minutes-units digit
    exp_out.segments     = SegFont[digit] ^ ((cur_slot == SlotMinUnits) ? 8'h7F : 8'hFF);
    exp_out.minutes      = TimeW'(shown_min.tens * 10 + shown_min.units);
    exp_out.seconds      = TimeW'(shown_sec.tens * 10 + shown_sec.units);
    display_due.push_back(exp_out);
    if (cur_slot == SlotSecUnits) begin
      cur_slot = SlotMinTens;
      limit    = (cfg_scans == '0) ? ScanW'(1) : cfg_scans;   // zero acts as one
      scan_cnt = scan_cnt + 1'b1;
      // a lowered limit already passed still advances on this scan
      if (scan_cnt >= limit || scan_cnt == '0) begin
        scan_cnt = '0;
        tick_second();
      end
    end else begin
      cur_slot = slot_e'(cur_slot + 2'd1);
    end
  endfunction

  // APB write, then read back when the address maps to a register
  task automatic reg_write(input logic [AddrW-1:0] addr, input logic [DataW-1:0] val);
    logic [DataW-1:0] held;
    logic             mapped;
    mapped = 1'b1;
    held   = '0;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    // register takes the value at this edge
    if (addr == reg_addr(RegStartMin)) begin
      cfg_start_min = val[TimeW-1:0];
      held          = DataW'(cfg_start_min);
    end else if (addr == reg_addr(RegStartSec)) begin
      cfg_start_sec = val[TimeW-1:0];
      held          = DataW'(cfg_start_sec);
    end else if (addr == reg_addr(RegScans)) begin
      cfg_scans = val[ScanW-1:0];
      held      = DataW'(cfg_scans);
    end else begin
      mapped = 1'b0;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    if (mapped) begin
      @(posedge clk_i);
      psel   <= 1'b1;
      pwrite <= 1'b0;
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      if (prdata !== held) report_mismatch("register readback", prdata, held);
      psel    <= 1'b0;
      penable <= 1'b0;
    end
  endtask

  // sender idle and every expected result back
  task automatic settle();
    forever begin
      @(negedge clk_i);
      if (reload_feed.size() == 0 && !s_axis_tvalid && display_due.size() == 0) break;
    end
  endtask

  task automatic feed(input bit lead_reload, input int plain);
    @(negedge clk_i);
    if (lead_reload) reload_feed.push_back(1'b1);
    repeat (plain) reload_feed.push_back(1'b0);
  endtask

  function automatic logic [TimeW-1:0] pick_time();
    case ($urandom_range(0, 7))
      0:       return 6'd0;
      1:       return 6'd59;
      2:       return TimeW'($urandom_range(60, 63));   // saturates to 59
      3, 4:    return TimeW'($urandom_range(50, 59));   // near the wrap
      default: return TimeW'($urandom_range(0, 63));
    endcase
  endfunction

  function automatic logic [ScanW-1:0] pick_scans();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 10'd1023;
      2, 3:    return 10'd1;
      4:       return ScanW'($urandom_range(5, 1023));
      default: return ScanW'($urandom_range(1, 4));
    endcase
  endfunction

  // ---------------------------------------------------------------- request driver

  always @(posedge clk_i) begin : request_drive
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        show_slot(s_axis_tdata[0]);
        slots_taken++;
      end
      // free to change tvalid only when nothing is stuck waiting
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (reload_feed.size() != 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {{(InW-1){1'b0}}, reload_feed.pop_front()};
          send_gap       = idle_len(send_quiet);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- result monitor

  always @(posedge clk_i) begin : result_check
    scan_out_t got;
    scan_out_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = scan_out_t'(m_axis_tdata);
        if (display_due.size() == 0) begin
          report_mismatch("result with nothing due", m_axis_tdata, '0);
        end else begin
          want = display_due.pop_front();
          if (got.digit_select !== want.digit_select)
            report_mismatch("digit_select", 32'(got.digit_select), 32'(want.digit_select));
          if (got.segments !== want.segments)
            report_mismatch("segments", 32'(got.segments), 32'(want.segments));
          if (got.minutes !== want.minutes)
            report_mismatch("minutes", 32'(got.minutes), 32'(want.minutes));
          if (got.seconds !== want.seconds)
            report_mismatch("seconds", 32'(got.seconds), 32'(want.seconds));
          if (got.pad !== want.pad)
            report_mismatch("tdata pad", 32'(got.pad), 32'(want.pad));
        end
        recv_gap = idle_len(recv_quiet);
      end
      if (holding) begin
        m_axis_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- long hold-off

  // Mid-run, block the result side while requests keep coming, so the block backs up
  // and drops s_axis_tready.
  initial begin : long_hold
    forever begin
      @(negedge clk_i);
      if (slots_taken >= 400 && reload_feed.size() > 40) break;
    end
    @(posedge clk_i);
    holding <= 1'b1;
    repeat (300) @(posedge clk_i);
    holding <= 1'b0;
  end

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    int fed_total;
    int n;
    fed_total     = 0;
    cfg_start_min = StartMinRst;
    cfg_start_sec = StartSecRst;
    cfg_scans     = ScansRst;
    load_start_time();
    cur_slot = SlotMinTens;
    scan_cnt = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed. Reset values: reload then two full scans, count left at 2.
    feed(1'b1, 7);
    settle();
    // limit below the running count: next full scan must advance 18:58 -> 18:59
    reg_write(reg_addr(RegScans), 32'd1);
    reg_write(AddrSpare, 32'hFFFF_FFFF);
    feed(1'b0, 4);
    settle();
    // start 63 saturates to 59, zero scans acts as one: 59:58, 59:59, wrap to 59:58
    reg_write(reg_addr(RegStartMin), {26'h3FF_FFFF, 6'd63});
    reg_write(reg_addr(RegStartSec), 32'd58);
    reg_write(reg_addr(RegScans), 32'd0);
    feed(1'b1, 11);
    settle();

    // Random phases: new settings between phases, occasional reloads inside.
    while (fed_total < RandItems) begin
      settle();
      if ($urandom_range(0, 1)) reg_write(reg_addr(RegStartMin), {26'($urandom()), pick_time()});
      if ($urandom_range(0, 1)) reg_write(reg_addr(RegStartSec), {26'($urandom()), pick_time()});
      if ($urandom_range(0, 1)) reg_write(reg_addr(RegScans), {22'($urandom()), pick_scans()});
      if ($urandom_range(0, 7) == 0) reg_write(AddrSpare, $urandom());
      @(negedge clk_i);
      send_quiet = ($urandom_range(0, 3) == 0);
      recv_quiet = ($urandom_range(0, 3) == 0);
      n = $urandom_range(100, 250);
      if ($urandom_range(0, 1)) reload_feed.push_back(1'b1);
      repeat (n) reload_feed.push_back($urandom_range(0, 31) == 0);
      fed_total += n;
    end

    settle();
    repeat (8) @(posedge clk_i);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // hard stop far beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
